@@ rtl/aws_pkg.sv @@
// Shared types and constants for the affine warp splat block.
// Used by every module in rtl/; depends on nothing else.
package aws_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int MAX_SPLAT = 4;
  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int GAIN_W  = 32;
  localparam int COLOR_W = 8;
  localparam int SIDE_W  = $clog2(MAX_SPLAT + 1);
  localparam int PROD_W  = GAIN_W + COORD_W + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int CLIP_W  = GAIN_W + 2;

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_COL_GAIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_COL_GAIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_COL_OFFSET = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW_GAIN_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW_GAIN_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW_OFFSET = 3'd5;
  localparam logic [IDX_W-1:0] REG_DEST_COLS  = 3'd6;
  localparam logic [IDX_W-1:0] REG_DEST_ROWS  = 3'd7;

  typedef struct packed {
    logic signed [GAIN_W-1:0] col_gain_x;
    logic signed [GAIN_W-1:0] col_gain_y;
    logic signed [GAIN_W-1:0] col_offset;
    logic signed [GAIN_W-1:0] row_gain_x;
    logic signed [GAIN_W-1:0] row_gain_y;
    logic signed [GAIN_W-1:0] row_offset;
    logic [DIM_W-1:0]         dest_cols;
    logic [DIM_W-1:0]         dest_rows;
  } cfg_t;

  // One clipped splat window, ready for scanning.
  typedef struct packed {
    logic [COORD_W-1:0] rs;
    logic [COORD_W-1:0] re;
    logic [COORD_W-1:0] cs;
    logic [COORD_W-1:0] ce;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } win_t;

endpackage

@@ rtl/aws_front.sv @@
// Front end: accepts source pixels, maps them through the affine matrix and
// clips the splat window to the destination. Depends on aws_pkg.
module aws_front (
  input  logic                                clk,
  input  logic                                rst,
  input  aws_pkg::cfg_t                       cfg,
  input  logic                                start,
  output logic                                busy,
  input  logic [aws_pkg::COORD_W-1:0]         pixel_col,
  input  logic [aws_pkg::COORD_W-1:0]         pixel_row,
  input  logic [aws_pkg::COLOR_W-1:0]         pixel_red,
  input  logic [aws_pkg::COLOR_W-1:0]         pixel_green,
  input  logic [aws_pkg::COLOR_W-1:0]         pixel_blue,
  input  logic [aws_pkg::CNT_W-1:0]           q_count,
  output logic                                push,
  output aws_pkg::win_t                       win
);

  logic accept;
  logic [aws_pkg::CNT_W:0] credit;

  // Stage 1: products and window side.
  logic s1v;
  logic signed [aws_pkg::PROD_W-1:0] p_cx, p_cy, p_rx, p_ry;
  logic signed [aws_pkg::GAIN_W-1:0] s1_coff, s1_roff;
  logic [aws_pkg::SIDE_W-1:0] s1_side;
  logic [aws_pkg::COLOR_W-1:0] s1_red, s1_green, s1_blue;

  // Stage 2: destination position.
  logic s2v;
  logic signed [aws_pkg::GAIN_W-1:0] s2_dc, s2_dr;
  logic [aws_pkg::SIDE_W-1:0] s2_side;
  logic [aws_pkg::COLOR_W-1:0] s2_red, s2_green, s2_blue;

  // Stage 3: clipped window.
  logic s3v;
  logic s3_hit;
  aws_pkg::win_t s3_win;

  logic signed [aws_pkg::GAIN_W-1:0] mx;
  logic [aws_pkg::GAIN_W:0] side_raw;
  logic [aws_pkg::SIDE_W-1:0] side_c;
  logic signed [aws_pkg::PROD_W-1:0] col_s, row_s;
  logic signed [aws_pkg::ACC_W-1:0] acc_c, acc_r;
  logic signed [aws_pkg::ACC_W-1:0] tr_c, tr_r;
  logic [aws_pkg::DIM_W-1:0] cols_cl, rows_cl;
  logic signed [aws_pkg::CLIP_W-1:0] lim_c, lim_r, end_c, end_r;
  logic signed [aws_pkg::CLIP_W-1:0] cs, ce, rs, re, side_x;
  logic hit;

  assign credit = (aws_pkg::CNT_W+1)'(s1v) + (aws_pkg::CNT_W+1)'(s2v)
                + (aws_pkg::CNT_W+1)'(s3v) + (aws_pkg::CNT_W+1)'(q_count);
  assign busy   = credit >= (aws_pkg::CNT_W+1)'(aws_pkg::QDEPTH);
  assign accept = start && !busy;

  always_comb begin
    mx = cfg.col_gain_x;
    if (cfg.col_gain_y > mx) mx = cfg.col_gain_y;
    if (cfg.row_gain_x > mx) mx = cfg.row_gain_x;
    if (cfg.row_gain_y > mx) mx = cfg.row_gain_y;
    // ceil(2*mx / 2^FRAC_BITS) is ceil(mx / 2^(FRAC_BITS-1)).
    side_raw = ({1'b0, mx} + (aws_pkg::GAIN_W+1)'((1 << (aws_pkg::FRAC_BITS - 1)) - 1))
               >> (aws_pkg::FRAC_BITS - 1);
    if (mx <= 0) begin
      side_c = '0;
    end else if (side_raw > (aws_pkg::GAIN_W+1)'(aws_pkg::MAX_SPLAT)) begin
      side_c = aws_pkg::SIDE_W'(aws_pkg::MAX_SPLAT);
    end else begin
      side_c = side_raw[aws_pkg::SIDE_W-1:0];
    end
  end

  assign col_s = $signed({{(aws_pkg::PROD_W-aws_pkg::COORD_W){1'b0}}, pixel_col});
  assign row_s = $signed({{(aws_pkg::PROD_W-aws_pkg::COORD_W){1'b0}}, pixel_row});

  always_ff @(posedge clk) begin
    p_cx     <= aws_pkg::PROD_W'(cfg.col_gain_x) * col_s;
    p_cy     <= aws_pkg::PROD_W'(cfg.col_gain_y) * row_s;
    p_rx     <= aws_pkg::PROD_W'(cfg.row_gain_x) * col_s;
    p_ry     <= aws_pkg::PROD_W'(cfg.row_gain_y) * row_s;
    s1_coff  <= cfg.col_offset;
    s1_roff  <= cfg.row_offset;
    s1_side  <= side_c;
    s1_red   <= pixel_red;
    s1_green <= pixel_green;
    s1_blue  <= pixel_blue;
  end

  always_comb begin
    acc_c = aws_pkg::ACC_W'(p_cx) + aws_pkg::ACC_W'(p_cy) + aws_pkg::ACC_W'(s1_coff);
    acc_r = aws_pkg::ACC_W'(p_rx) + aws_pkg::ACC_W'(p_ry) + aws_pkg::ACC_W'(s1_roff);
    // Bias negative sums so the arithmetic shift truncates toward zero.
    tr_c = (acc_c < 0)
         ? (acc_c + aws_pkg::ACC_W'((1 << aws_pkg::FRAC_BITS) - 1)) >>> aws_pkg::FRAC_BITS
         : acc_c >>> aws_pkg::FRAC_BITS;
    tr_r = (acc_r < 0)
         ? (acc_r + aws_pkg::ACC_W'((1 << aws_pkg::FRAC_BITS) - 1)) >>> aws_pkg::FRAC_BITS
         : acc_r >>> aws_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    s2_dc    <= tr_c[aws_pkg::GAIN_W-1:0];
    s2_dr    <= tr_r[aws_pkg::GAIN_W-1:0];
    s2_side  <= s1_side;
    s2_red   <= s1_red;
    s2_green <= s1_green;
    s2_blue  <= s1_blue;
  end

  always_comb begin
    cols_cl = (cfg.dest_cols > aws_pkg::DIM_W'(aws_pkg::MAX_DIM))
            ? aws_pkg::DIM_W'(aws_pkg::MAX_DIM) : cfg.dest_cols;
    rows_cl = (cfg.dest_rows > aws_pkg::DIM_W'(aws_pkg::MAX_DIM))
            ? aws_pkg::DIM_W'(aws_pkg::MAX_DIM) : cfg.dest_rows;
    lim_c  = $signed({{(aws_pkg::CLIP_W-aws_pkg::DIM_W){1'b0}}, cols_cl}) - 1;
    lim_r  = $signed({{(aws_pkg::CLIP_W-aws_pkg::DIM_W){1'b0}}, rows_cl}) - 1;
    side_x = $signed({{(aws_pkg::CLIP_W-aws_pkg::SIDE_W){1'b0}}, s2_side});
    end_c  = aws_pkg::CLIP_W'(s2_dc) + side_x - 1;
    end_r  = aws_pkg::CLIP_W'(s2_dr) + side_x - 1;
    cs = (s2_dc < 0) ? '0 : aws_pkg::CLIP_W'(s2_dc);
    rs = (s2_dr < 0) ? '0 : aws_pkg::CLIP_W'(s2_dr);
    ce = (end_c < lim_c) ? end_c : lim_c;
    re = (end_r < lim_r) ? end_r : lim_r;
    hit = (s2_side != '0) && (cs <= ce) && (rs <= re);
  end

  always_ff @(posedge clk) begin
    s3_hit       <= hit;
    s3_win.rs    <= rs[aws_pkg::COORD_W-1:0];
    s3_win.re    <= re[aws_pkg::COORD_W-1:0];
    s3_win.cs    <= cs[aws_pkg::COORD_W-1:0];
    s3_win.ce    <= ce[aws_pkg::COORD_W-1:0];
    s3_win.red   <= s2_red;
    s3_win.green <= s2_green;
    s3_win.blue  <= s2_blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
    end else begin
      s1v <= accept;
      s2v <= s1v;
      s3v <= s2v;
    end
  end

  // Pixels whose window misses the destination are dropped here.
  assign push = s3v && s3_hit;
  assign win  = s3_win;

endmodule

@@ rtl/aws_queue.sv @@
// Short window queue between the front end and the scanner.
// Depends on aws_pkg.
module aws_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  aws_pkg::win_t             push_win,
  input  logic                      pop,
  output aws_pkg::win_t             head,
  output logic                      q_valid,
  output logic [aws_pkg::CNT_W-1:0] q_count
);

  aws_pkg::win_t mem [aws_pkg::QDEPTH];
  logic [aws_pkg::PTR_W-1:0] rd_ptr, wr_ptr;
  logic [aws_pkg::CNT_W-1:0] count;
  logic do_pop;

  assign do_pop  = pop && (count != '0);
  assign q_valid = count != '0;
  assign q_count = count;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_win;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/aws_back.sv @@
// Back end: scans one clipped window row-major and issues one write per cycle.
// Depends on aws_pkg.
module aws_back (
  input  logic                        clk,
  input  logic                        rst,
  input  aws_pkg::win_t               head,
  input  logic                        q_valid,
  output logic                        pop,
  output logic                        strobe,
  output logic [aws_pkg::COORD_W-1:0] write_col,
  output logic [aws_pkg::COORD_W-1:0] write_row,
  output logic [aws_pkg::COLOR_W-1:0] write_red,
  output logic [aws_pkg::COLOR_W-1:0] write_green,
  output logic [aws_pkg::COLOR_W-1:0] write_blue,
  output logic                        last_write
);

  logic active;
  aws_pkg::win_t cur;
  logic [aws_pkg::COORD_W-1:0] row, col;
  logic last_pos;

  // The window is already clipped, so its far corner is the final write.
  assign last_pos = active && (row == cur.re) && (col == cur.ce);
  assign pop      = q_valid && (!active || last_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (last_pos) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      row <= head.rs;
      col <= head.cs;
    end else if (active) begin
      if (col == cur.ce) begin
        col <= cur.cs;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    write_col   <= col;
    write_row   <= row;
    write_red   <= cur.red;
    write_green <= cur.green;
    write_blue  <= cur.blue;
    last_write  <= last_pos;
  end

endmodule

@@ rtl/affine_warp_splat_top.sv @@
// The first write of a pixel passes front stages s1, s2 and s3, the window queue,
// the scanner's window register and the output registers. The scanner issues one
// write per cycle while it scans a window; a clipped window has 1 to MAX_SPLAT
// squared positions, and pixels whose window misses the destination never reach
// the scanner. busy is set by the credit count of the 3-stage front pipeline plus
// the 4-entry window queue. Synchronous reset clears control state and loads defaults.
module affine_warp_splat_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [aws_pkg::COORD_W-1:0] pixel_col,
  input  logic [aws_pkg::COORD_W-1:0] pixel_row,
  input  logic [aws_pkg::COLOR_W-1:0] pixel_red,
  input  logic [aws_pkg::COLOR_W-1:0] pixel_green,
  input  logic [aws_pkg::COLOR_W-1:0] pixel_blue,
  input  logic                        cfg_write,
  input  logic [aws_pkg::IDX_W-1:0]   cfg_index,
  input  logic [aws_pkg::GAIN_W-1:0]  cfg_data,
  output logic                        strobe,
  output logic [aws_pkg::COORD_W-1:0] write_col,
  output logic [aws_pkg::COORD_W-1:0] write_row,
  output logic [aws_pkg::COLOR_W-1:0] write_red,
  output logic [aws_pkg::COLOR_W-1:0] write_green,
  output logic [aws_pkg::COLOR_W-1:0] write_blue,
  output logic                        last_write
);

  aws_pkg::cfg_t cfg;
  aws_pkg::win_t push_win, head;
  logic push, pop, q_valid;
  logic [aws_pkg::CNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_gain_x <= 32'sd65536;
      cfg.col_gain_y <= '0;
      cfg.col_offset <= '0;
      cfg.row_gain_x <= '0;
      cfg.row_gain_y <= 32'sd65536;
      cfg.row_offset <= '0;
      cfg.dest_cols  <= 13'd640;
      cfg.dest_rows  <= 13'd480;
    end else if (cfg_write) begin
      case (cfg_index)
        aws_pkg::REG_COL_GAIN_X: cfg.col_gain_x <= cfg_data;
        aws_pkg::REG_COL_GAIN_Y: cfg.col_gain_y <= cfg_data;
        aws_pkg::REG_COL_OFFSET: cfg.col_offset <= cfg_data;
        aws_pkg::REG_ROW_GAIN_X: cfg.row_gain_x <= cfg_data;
        aws_pkg::REG_ROW_GAIN_Y: cfg.row_gain_y <= cfg_data;
        aws_pkg::REG_ROW_OFFSET: cfg.row_offset <= cfg_data;
        aws_pkg::REG_DEST_COLS:  cfg.dest_cols  <= cfg_data[aws_pkg::DIM_W-1:0];
        aws_pkg::REG_DEST_ROWS:  cfg.dest_rows  <= cfg_data[aws_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  aws_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (start),
    .busy        (busy),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .q_count     (q_count),
    .push        (push),
    .win         (push_win)
  );

  aws_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_win (push_win),
    .pop      (pop),
    .head     (head),
    .q_valid  (q_valid),
    .q_count  (q_count)
  );

  aws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_valid     (q_valid),
    .pop         (pop),
    .strobe      (strobe),
    .write_col   (write_col),
    .write_row   (write_row),
    .write_red   (write_red),
    .write_green (write_green),
    .write_blue  (write_blue),
    .last_write  (last_write)
  );

`ifndef SYNTH
  // The credit check must keep the queue from ever taking a window when full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count != aws_pkg::CNT_W'(aws_pkg::QDEPTH)) || pop)
    else $error("window queue overflow");

  // A window keeps writing every cycle until its final transfer.
  a_window_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_write |=> strobe)
    else $error("gap inside a splat window");

  // Inside one window the row either holds or advances by one.
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_write |=> (write_row == $past(write_row)) ||
                              (write_row == $past(write_row) + 1'b1))
    else $error("row jump inside a splat window");
`endif

endmodule
